[rtl/core/round_robin_quantum_scheduler_top_defines.svh]
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_TOP_DEFINES_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_TOP_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define RRQS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scheduler port check failed");

// Property that must hold in the cycle after its antecedent.
`define RRQS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scheduler port check failed");

`endif

[rtl/core/rrqs_pkg.sv]
package rrqs_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TIME_WIDTH_DEF  = 16;

	localparam int OPCODE_W  = 2;
	localparam int STATUS_W  = 4;
	localparam int QUANTUM_W = 16;
	localparam int SERVED_W  = 16;
	localparam int AVG_W     = 24;
	localparam int FRAC_W    = 8;
	localparam int M_DATA_W  = SERVED_W + AVG_W;

	localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};

	typedef enum logic [OPCODE_W-1:0] {
		OP_ADD     = 2'd0,
		OP_SERVE   = 2'd1,
		OP_REPORT  = 2'd2,
		OP_INVALID = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_FINISHED     = 4'd0,
		ST_REQUEUED     = 4'd1,
		ST_EMPTY        = 4'd2,
		ST_ADDED        = 4'd3,
		ST_ZERO         = 4'd4,
		ST_FULL         = 4'd5,
		ST_BADOP        = 4'd6,
		ST_AVERAGE      = 4'd7,
		ST_REPORT_EMPTY = 4'd8
	} status_t;

endpackage

[rtl/core/rrqs_ring.sv]
module rrqs_ring #(
	parameter int DEPTH  = 16,
	parameter int WIDTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/core/rrqs_divider.sv]
module rrqs_divider #(
	parameter int NUM_W = 29,
	parameter int DEN_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quot_q;
	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W-1:0] rem_n;

	// Restoring division: one quotient bit per cycle, dividend bits shift out
	// of the top of the quotient register as quotient bits shift in.
	assign trial = {rem_q, quot_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign rem_n = ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			den_q  <= den;
			quot_q <= num;
		end else if (cnt_q != '0) begin
			rem_q  <= rem_n;
			quot_q <= {quot_q[NUM_W-2:0], ge};
		end
	end

	assign busy = cnt_q != '0;
	assign quot = quot_q;

endmodule

[rtl/core/round_robin_quantum_scheduler_top.sv]
// Round-robin time-slice scheduler over a ring of remaining job times. Each input beat carries an
// opcode in s_tuser and a burst time in s_tdata; each produces exactly one result beat with the
// granted time and mean in m_tdata and the status code in m_tuser. Add, serve and invalid
// opcodes present their result from the execute state once the output register is free, after
// the registered read port of the job ring has delivered the head time. A report with jobs
// queued passes on to the divide state and presents its result once the restoring divider, which
// yields one quotient bit per cycle, has produced every quotient bit and the output register is
// free. A new beat is taken only once the previous one has finished, and a finished result waits
// in the output register without holding up the next input beat.
module round_robin_quantum_scheduler_top
	import rrqs_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
	localparam int S_DATA_W   = ((TIME_WIDTH + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [QUANTUM_W-1:0] cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,   // job_time
	input  logic [OPCODE_W-1:0]  s_tuser,   // opcode
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_DATA_W-1:0]  m_tdata,   // served_time, average_fixed
	output logic [STATUS_W-1:0]  m_tuser    // status
);

	localparam int ADDR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int PTR_W  = CNT_W + 1;
	localparam int SUM_W  = TIME_WIDTH + CNT_W;
	localparam int NUM_W  = SUM_W + FRAC_W;
	localparam int CMP_W  = (TIME_WIDTH > QUANTUM_W) ? TIME_WIDTH : QUANTUM_W;
	localparam int EXT_W  = (TIME_WIDTH > SERVED_W) ? TIME_WIDTH : SERVED_W;
	localparam int QX_W   = (NUM_W > AVG_W) ? NUM_W : AVG_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIVIDE
	} state_t;

	state_t               state_q;
	opcode_t              op_q;
	logic [TIME_WIDTH-1:0] time_q;
	logic [ADDR_W-1:0]    head_q;
	logic [CNT_W-1:0]     count_q;
	logic [SUM_W-1:0]     sum_q;
	logic [QUANTUM_W-1:0] quantum_q;
	logic                 m_tvalid_q;
	logic [SERVED_W-1:0]  m_served_q;
	status_t              m_status_q;
	logic [AVG_W-1:0]     m_avg_q;

	logic [QUANTUM_W-1:0]  q_eff;
	logic [PTR_W-1:0]      tail_raw;
	logic [ADDR_W-1:0]     tail_idx;
	logic [ADDR_W-1:0]     head_next;
	logic [TIME_WIDTH-1:0] head_time;
	logic [CMP_W-1:0]      h_c;
	logic [CMP_W-1:0]      q_c;
	logic [CMP_W-1:0]      rem_c;
	logic [TIME_WIDTH-1:0] rem_t;
	logic [EXT_W-1:0]      h_ext;
	logic                  fits;
	logic                  is_full;
	logic                  is_empty;
	logic                  out_free;
	logic                  m_load;
	logic                  ring_wr_en;
	logic [TIME_WIDTH-1:0] ring_wr_data;
	logic                  div_start;
	logic                  div_busy;
	logic [NUM_W-1:0]      div_quot;
	logic [QX_W-1:0]       quot_x;
	logic [AVG_W-1:0]      avg_sat;

	assign q_eff     = (quantum_q == '0) ? QUANTUM_W'(1) : quantum_q;
	assign tail_raw  = PTR_W'(head_q) + PTR_W'(count_q);
	assign tail_idx  = (tail_raw >= PTR_W'(QUEUE_DEPTH)) ?
		ADDR_W'(tail_raw - PTR_W'(QUEUE_DEPTH)) : ADDR_W'(tail_raw);
	assign head_next = (head_q == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + ADDR_W'(1);

	assign h_c   = CMP_W'(head_time);
	assign q_c   = CMP_W'(q_eff);
	assign fits  = h_c <= q_c;
	assign rem_c = h_c - q_c;
	assign rem_t = rem_c[TIME_WIDTH-1:0];
	assign h_ext = EXT_W'(head_time);

	assign is_full  = count_q == CNT_W'(QUEUE_DEPTH);
	assign is_empty = count_q == '0;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_load   = out_free &&
		(((state_q == S_EXEC) && !((op_q == OP_REPORT) && !is_empty)) ||
		 ((state_q == S_DIVIDE) && !div_busy));

	assign ring_wr_en = (state_q == S_EXEC) && out_free &&
		(((op_q == OP_ADD) && (time_q != '0) && !is_full) ||
		 ((op_q == OP_SERVE) && !is_empty && !fits));
	assign ring_wr_data = (op_q == OP_ADD) ? time_q : rem_t;

	assign div_start = (state_q == S_EXEC) && (op_q == OP_REPORT) && !is_empty;

	assign quot_x  = QX_W'(div_quot);
	assign avg_sat = (quot_x > QX_W'(AVG_MAX)) ? AVG_MAX : quot_x[AVG_W-1:0];

	rrqs_ring #(
		.DEPTH  (QUEUE_DEPTH),
		.WIDTH  (TIME_WIDTH),
		.ADDR_W (ADDR_W)
	) u_ring (
		.clk     (clk),
		.wr_en   (ring_wr_en),
		.wr_addr (tail_idx),
		.wr_data (ring_wr_data),
		.rd_addr (head_q),
		.rd_data (head_time)
	);

	rrqs_divider #(
		.NUM_W (NUM_W),
		.DEN_W (CNT_W)
	) u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({sum_q, {FRAC_W{1'b0}}}),
		.den    (count_q),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= OP_INVALID;
			time_q     <= '0;
			head_q     <= '0;
			count_q    <= '0;
			sum_q      <= '0;
			quantum_q  <= QUANTUM_W'(1);
			m_tvalid_q <= 1'b0;
			m_served_q <= '0;
			m_status_q <= ST_BADOP;
			m_avg_q    <= '0;
		end else begin
			if (cfg_wen) begin
				quantum_q <= cfg_wdata;
			end
			if (m_tvalid_q && m_tready && !m_load) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= opcode_t'(s_tuser);
						time_q  <= s_tdata[TIME_WIDTH-1:0];
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if ((op_q == OP_REPORT) && !is_empty) begin
						state_q <= S_DIVIDE;
					end else if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_served_q <= '0;
						m_avg_q    <= '0;
						state_q    <= S_IDLE;
						case (op_q)
							OP_ADD: begin
								if (time_q == '0) begin
									m_status_q <= ST_ZERO;
								end else if (is_full) begin
									m_status_q <= ST_FULL;
								end else begin
									count_q    <= count_q + CNT_W'(1);
									sum_q      <= sum_q + SUM_W'(time_q);
									m_status_q <= ST_ADDED;
								end
							end
							OP_SERVE: begin
								if (is_empty) begin
									m_status_q <= ST_EMPTY;
								end else if (fits) begin
									head_q     <= head_next;
									count_q    <= count_q - CNT_W'(1);
									sum_q      <= sum_q - SUM_W'(head_time);
									m_served_q <= h_ext[SERVED_W-1:0];
									m_status_q <= ST_FINISHED;
								end else begin
									head_q     <= head_next;
									sum_q      <= sum_q - SUM_W'(head_time) + SUM_W'(rem_t);
									m_served_q <= q_eff;
									m_status_q <= ST_REQUEUED;
								end
							end
							OP_REPORT: begin
								m_status_q <= ST_REPORT_EMPTY;
							end
							default: begin
								m_status_q <= ST_BADOP;
							end
						endcase
					end
				end
				S_DIVIDE: begin
					if (!div_busy && out_free) begin
						m_tvalid_q <= 1'b1;
						m_served_q <= '0;
						m_avg_q    <= avg_sat;
						m_status_q <= ST_AVERAGE;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {m_avg_q, m_served_q};
	assign m_tuser  = m_status_q;

endmodule

[rtl/core/rrqs_checker.sv]
`include "round_robin_quantum_scheduler_top_defines.svh"

module rrqs_checker
	import rrqs_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic [STATUS_W-1:0] m_tuser
);

	// A stalled result beat keeps its contents.
	`RRQS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// Once a beat is taken, the block works on it before taking another.
	`RRQS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// Only serve results carry a granted time.
	`RRQS_ASSERT_IMPLY(a_served_zero, clk, arst_n, m_tvalid && (m_tuser != ST_FINISHED) && (m_tuser != ST_REQUEUED), m_tdata[SERVED_W-1:0] == '0)

	// Only an average result carries a mean.
	`RRQS_ASSERT_IMPLY(a_avg_zero, clk, arst_n, m_tvalid && (m_tuser != ST_AVERAGE), m_tdata[M_DATA_W-1:SERVED_W] == '0)

endmodule

bind round_robin_quantum_scheduler_top rrqs_checker u_rrqs_checker (.*);
